[rtl/core/segint_pkg.sv]
package segint_pkg;

   localparam int COORD_BITS   = 31;
   localparam int DIFF_BITS    = COORD_BITS + 1;
   localparam int PROD_BITS    = 2 * DIFF_BITS;
   localparam int ORIENT_COUNT = 4;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef struct packed {
      diff_type ux;
      diff_type vy;
      diff_type wx;
      diff_type zy;
   } cross_terms_type;

   typedef struct packed {
      logic                                 valid;
      cross_terms_type [ORIENT_COUNT-1:0] terms;
      point_type                            lo1;
      point_type                            hi1;
      point_type                            lo2;
      point_type                            hi2;
   } prep_type;

   typedef struct packed {
      prod_type p;
      prod_type q;
   } prod_pair_type;

   typedef struct packed {
      logic   c_lt_b;
      logic   a_lt_d;
      logic   b_lt_c;
      logic   d_lt_a;
   } order_type;

   typedef struct packed {
      logic                               valid;
      prod_pair_type [ORIENT_COUNT-1:0] prods;
      order_type                          order;
   } mul_type;

   typedef struct packed {
      logic                    valid;
      logic [ORIENT_COUNT-1:0] zero;
      logic [ORIENT_COUNT-1:0] neg;
      order_type               order;
   } sign_type;

   typedef enum logic [1:0] {
      KIND_DISJOINT = 2'd0,
      KIND_CROSS    = 2'd1,
      KIND_TOUCH    = 2'd2,
      KIND_OVERLAP  = 2'd3
   } meet_kind_type;

   function automatic logic pt_less(point_type p, point_type q);
      return ($signed(p.x) < $signed(q.x)) ||
             ((p.x == q.x) && ($signed(p.y) < $signed(q.y)));
   endfunction

   function automatic diff_type coord_diff(coord_type a, coord_type b);
      diff_type wa;
      diff_type wb;
      wa = diff_type'($signed(a));
      wb = diff_type'($signed(b));
      return diff_type'(wa - wb);
   endfunction

   function automatic cross_terms_type terms_of(point_type p, point_type q, point_type r);
      cross_terms_type t;
      t.ux = coord_diff(q.x, p.x);
      t.vy = coord_diff(r.y, q.y);
      t.wx = coord_diff(r.x, q.x);
      t.zy = coord_diff(q.y, p.y);
      return t;
   endfunction

endpackage

[rtl/core/segint_prep.sv]
module segint_prep (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  segint_pkg::point_type pt_a,
   input  segint_pkg::point_type pt_b,
   input  segint_pkg::point_type pt_c,
   input  segint_pkg::point_type pt_d,
   output segint_pkg::prep_type  prep
);
   import segint_pkg::*;

   prep_type prep_ff;
   prep_type prep_in;
   logic     swap1;
   logic     swap2;

   always_comb begin
      swap1            = pt_less(pt_b, pt_a);
      swap2            = pt_less(pt_d, pt_c);
      prep_in.valid    = in_valid;
      prep_in.terms[0] = terms_of(pt_a, pt_b, pt_c);
      prep_in.terms[1] = terms_of(pt_a, pt_b, pt_d);
      prep_in.terms[2] = terms_of(pt_c, pt_d, pt_a);
      prep_in.terms[3] = terms_of(pt_c, pt_d, pt_b);
      prep_in.lo1      = swap1 ? pt_b : pt_a;
      prep_in.hi1      = swap1 ? pt_a : pt_b;
      prep_in.lo2      = swap2 ? pt_d : pt_c;
      prep_in.hi2      = swap2 ? pt_c : pt_d;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff <= '0;
      end else begin
         prep_ff <= prep_in;
      end
   end

   assign prep = prep_ff;

endmodule

[rtl/core/segint_orient.sv]
module segint_orient (
   input  logic                 clock,
   input  logic                 reset,
   input  segint_pkg::prep_type prep,
   output segint_pkg::sign_type sign
);
   import segint_pkg::*;

   mul_type  mul_ff;
   mul_type  mul_in;
   sign_type sign_ff;
   sign_type sign_in;

   always_comb begin
      mul_in.valid = prep.valid;
      for (int i = 0; i < ORIENT_COUNT; i++) begin
         mul_in.prods[i].p = prod_type'($signed(prep.terms[i].ux)) *
                             prod_type'($signed(prep.terms[i].vy));
         mul_in.prods[i].q = prod_type'($signed(prep.terms[i].wx)) *
                             prod_type'($signed(prep.terms[i].zy));
      end
      mul_in.order.c_lt_b = pt_less(prep.lo2, prep.hi1);
      mul_in.order.a_lt_d = pt_less(prep.lo1, prep.hi2);
      mul_in.order.b_lt_c = pt_less(prep.hi1, prep.lo2);
      mul_in.order.d_lt_a = pt_less(prep.hi2, prep.lo1);
   end

   always_comb begin
      sign_in.valid = mul_ff.valid;
      sign_in.order = mul_ff.order;
      for (int i = 0; i < ORIENT_COUNT; i++) begin
         sign_in.zero[i] = (mul_ff.prods[i].p == mul_ff.prods[i].q);
         sign_in.neg[i]  = ($signed(mul_ff.prods[i].p) < $signed(mul_ff.prods[i].q));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= '0;
         sign_ff <= '0;
      end else begin
         mul_ff  <= mul_in;
         sign_ff <= sign_in;
      end
   end

   assign sign = sign_ff;

   a_valid_chain: assert property (@(posedge clock) disable iff (reset)
      prep.valid |=> ##1 sign_ff.valid)
      else $error("orientation stage dropped a word");

   a_zero_not_neg: assert property (@(posedge clock) disable iff (reset)
      sign_ff.valid |-> ((sign_ff.zero & sign_ff.neg) == '0))
      else $error("orientation both zero and negative");

endmodule

[rtl/core/segint_classify.sv]
module segint_classify (
   input  logic                      clock,
   input  logic                      reset,
   input  segint_pkg::sign_type      sign,
   output logic                      strobe,
   output segint_pkg::meet_kind_type kind
);
   import segint_pkg::*;

   logic          strobe_ff;
   logic          strobe_in;
   meet_kind_type kind_ff;
   meet_kind_type kind_in;
   logic          s1_neg;
   logic          s2_neg;
   logic          s1_zero;
   logic          s2_zero;
   logic          all_zero;

   always_comb begin
      s1_zero  = sign.zero[0] | sign.zero[1];
      s2_zero  = sign.zero[2] | sign.zero[3];
      s1_neg   = !s1_zero && (sign.neg[0] ^ sign.neg[1]);
      s2_neg   = !s2_zero && (sign.neg[2] ^ sign.neg[3]);
      all_zero = &sign.zero;
      strobe_in = sign.valid;
      if (s1_neg && s2_neg) begin
         kind_in = KIND_CROSS;
      end else if (s1_zero && s2_zero) begin
         if (all_zero && sign.order.c_lt_b && sign.order.a_lt_d) begin
            kind_in = KIND_OVERLAP;
         end else if (!sign.order.b_lt_c && !sign.order.d_lt_a) begin
            kind_in = KIND_TOUCH;
         end else begin
            kind_in = KIND_DISJOINT;
         end
      end else if ((s1_neg || s1_zero) && (s2_neg || s2_zero)) begin
         kind_in = KIND_TOUCH;
      end else begin
         kind_in = KIND_DISJOINT;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   assign strobe = strobe_ff;
   assign kind   = kind_ff;

   a_overlap_collinear: assert property (@(posedge clock) disable iff (reset)
      (sign.valid && !(&sign.zero)) |=> (kind_ff != KIND_OVERLAP))
      else $error("overlap reported for non-collinear segments");

endmodule

[rtl/core/segment_intersection_classify.sv]
// Segment pair classifier.
// Input: drive the eight req_ coordinates (two endpoints per segment) and
// raise start; a word is taken at each clock edge with start high and busy
// low. busy never rises, so a new word may be offered every cycle.
// Output: rsp_strobe is high for one cycle with rsp_meet_kind valid:
// 0 disjoint, 1 proper crossing, 2 touching, 3 collinear overlap.
// Throughput is one pair per cycle. The four stages are endpoint
// differences and sorting, the eight signed 32x32 cross products, the
// product compares, and the final classification register.
// Reset clears all stage valid bits; no result comes out of a word that
// was in flight. The receiver cannot hold results off: a result is on the
// ports for exactly its strobe cycle and is gone after it.
module segment_intersection_classify (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  segint_pkg::coord_type         req_seg1_start_x,
   input  segint_pkg::coord_type         req_seg1_start_y,
   input  segint_pkg::coord_type         req_seg1_end_x,
   input  segint_pkg::coord_type         req_seg1_end_y,
   input  segint_pkg::coord_type         req_seg2_start_x,
   input  segint_pkg::coord_type         req_seg2_start_y,
   input  segint_pkg::coord_type         req_seg2_end_x,
   input  segint_pkg::coord_type         req_seg2_end_y,
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_meet_kind
);
   import segint_pkg::*;

   point_type     pt_a;
   point_type     pt_b;
   point_type     pt_c;
   point_type     pt_d;
   prep_type      prep;
   sign_type      sign;
   meet_kind_type kind;
   logic          accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign pt_a = '{x: req_seg1_start_x, y: req_seg1_start_y};
   assign pt_b = '{x: req_seg1_end_x,   y: req_seg1_end_y};
   assign pt_c = '{x: req_seg2_start_x, y: req_seg2_start_y};
   assign pt_d = '{x: req_seg2_end_x,   y: req_seg2_end_y};

   segint_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .pt_a     (pt_a),
      .pt_b     (pt_b),
      .pt_c     (pt_c),
      .pt_d     (pt_d),
      .prep     (prep)
   );

   segint_orient u_orient (
      .clock (clock),
      .reset (reset),
      .prep  (prep),
      .sign  (sign)
   );

   segint_classify u_classify (
      .clock  (clock),
      .reset  (reset),
      .sign   (sign),
      .strobe (rsp_strobe),
      .kind   (kind)
   );

   assign rsp_meet_kind = kind;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_strobe)
      else $error("accepted word produced no result");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(start, 4) && !$past(busy, 4)))
      else $error("result without an accepted word");

endmodule
